### hw/rtl/isa_pkg.sv
// isa_pkg: shared types and constants for the integer stack with average.
// No dependencies; imported by isa_div, integer_stack_with_average and tb_top.
`default_nettype none
package isa_pkg;

  localparam int VAL_W     = 32;
  localparam int SUM_W     = 40;
  localparam int FRAC_W    = 8;
  localparam int DVD_W     = SUM_W + FRAC_W;
  localparam int STEP_W    = $clog2(DVD_W);
  localparam int CNT_OUT_W = 9;
  localparam int STATUS_W  = 2;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/isa_div.sv
// isa_div: radix-2 restoring divider, one quotient bit per cycle, sign by magnitude.
// Depends on isa_pkg for the dividend and quotient widths.
`default_nettype none
module isa_div import isa_pkg::*; #(
  parameter int DEN_W = 9
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               neg,
  input  wire logic [DVD_W-1:0]   dividend_mag,
  input  wire logic [DEN_W-1:0]   divisor,
  output logic                    done,
  output logic [SUM_W-1:0]        quotient
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [DVD_W-1:0]   q_r, q_nxt;
  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic               neg_r, neg_nxt;
  logic [DEN_W:0]     rem_sh;
  logic [DEN_W:0]     diff;

  always_comb begin
    rem_sh   = {rem_r, q_r[DVD_W-1]};
    diff     = rem_sh - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = dividend_mag;
      rem_nxt  = '0;
      den_nxt  = divisor;
      neg_nxt  = neg;
    end else if (busy_r) begin
      if (diff[DEN_W]) begin
        rem_nxt = rem_sh[DEN_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[DEN_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (SUM_W'(0) - q_r[SUM_W-1:0]) : q_r[SUM_W-1:0];

endmodule
`default_nettype wire

### hw/rtl/integer_stack_with_average.sv
// integer_stack_with_average: LIFO stack of signed words with a running mean.
// Depends on isa_pkg and isa_div.
//
//   port group  | direction | beat carries
//   in_         | input     | func, push_value
//   out_        | output    | top_elem, stack_empty, element_count, mean_fixed,
//               |           | mean_valid, status
//
// Each item passes from accept through ST_LOAD, the 48-step bit-serial divider for the mean in
// ST_DIV, and ST_DONE; when the stack ends empty, ST_DIV and the division are skipped.
// in_stall is high from accept until the result is loaded into the output register,
// so no new beat is taken while an item is still in progress.
// A result waiting under out_stall does not block the next accept.
// rst_n empties the stack and clears the running sum; store contents are kept.
`default_nettype none
module integer_stack_with_average import isa_pkg::*; #(
  parameter int STACK_DEPTH = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_func,
  input  wire logic signed [VAL_W-1:0]     in_push_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [VAL_W-1:0]          out_top_elem,
  output logic                             out_stack_empty,
  output logic [CNT_OUT_W-1:0]             out_element_count,
  output logic signed [SUM_W-1:0]          out_mean_fixed,
  output logic                             out_mean_valid,
  output logic [STATUS_W-1:0]              out_status
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  logic [VAL_W-1:0] stack_store [STACK_DEPTH];

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [VAL_W-1:0]    top_r, top_nxt;
  logic [VAL_W-1:0]    rd_data_r;
  logic                pop_pend_r, pop_pend_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic                in_accept;
  logic                full;
  logic                empty;
  logic                mem_we;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic                out_load;
  logic                div_start;
  logic                div_done;
  logic [DVD_W-1:0]    dividend;
  logic [DVD_W-1:0]    dividend_mag;
  logic [SUM_W-1:0]    quotient;

  logic                    out_valid_r;
  logic [VAL_W-1:0]        out_top_r;
  logic                    out_empty_r;
  logic [CNT_OUT_W-1:0]    out_count_r;
  logic [SUM_W-1:0]        out_mean_r;
  logic                    out_mvalid_r;
  logic [STATUS_W-1:0]     out_status_r;

  assign in_accept = (state_r == ST_IDLE) && in_valid;
  assign in_stall  = (state_r != ST_IDLE);
  assign full      = (count_r >= CNT_W'(STACK_DEPTH));
  assign empty     = (count_r == '0);
  assign wr_addr   = count_r[ADDR_W-1:0];
  assign rd_addr   = ADDR_W'(count_r - CNT_W'(2));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = empty ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    top_nxt      = top_r;
    pop_pend_nxt = pop_pend_r;
    status_nxt   = status_r;
    mem_we       = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          pop_pend_nxt = 1'b0;
          status_nxt   = STATUS_OK;
          if (in_func == FUNC_PUSH) begin
            if (full) begin
              status_nxt = STATUS_PUSH_FULL;
            end else begin
              mem_we    = 1'b1;
              top_nxt   = in_push_value;
              count_nxt = count_r + CNT_W'(1);
              sum_nxt   = sum_r + {{(SUM_W-VAL_W){in_push_value[VAL_W-1]}}, in_push_value};
            end
          end else begin
            if (empty) begin
              status_nxt = STATUS_POP_EMPTY;
            end else begin
              pop_pend_nxt = 1'b1;
              count_nxt    = count_r - CNT_W'(1);
              sum_nxt      = sum_r - {{(SUM_W-VAL_W){top_r[VAL_W-1]}}, top_r};
            end
          end
        end
      end
      ST_LOAD: begin
        if (pop_pend_r) top_nxt = rd_data_r;
        div_start = !empty;
      end
      ST_DIV: begin
      end
      ST_DONE: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  assign dividend     = {sum_r, {FRAC_W{1'b0}}};
  assign dividend_mag = sum_r[SUM_W-1] ? (DVD_W'(0) - dividend) : dividend;

  isa_div #(
    .DEN_W (CNT_W)
  ) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (div_start),
    .neg          (sum_r[SUM_W-1]),
    .dividend_mag (dividend_mag),
    .divisor      (count_r),
    .done         (div_done),
    .quotient     (quotient)
  );

  always_ff @(posedge clk) begin
    if (mem_we) stack_store[wr_addr] <= in_push_value;
    rd_data_r <= stack_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      sum_r      <= '0;
      pop_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      pop_pend_r <= pop_pend_nxt;
    end
    top_r    <= top_nxt;
    status_r <= status_nxt;
  end

  // hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_top_r    <= empty ? '0 : top_r;
      out_empty_r  <= empty;
      out_count_r  <= CNT_OUT_W'(count_r);
      out_mean_r   <= empty ? '0 : quotient;
      out_mvalid_r <= !empty;
      out_status_r <= status_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_top_elem      = out_top_r;
  assign out_stack_empty   = out_empty_r;
  assign out_element_count = out_count_r;
  assign out_mean_fixed    = out_mean_r;
  assign out_mean_valid    = out_mvalid_r;
  assign out_status        = out_status_r;

endmodule
`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking testbench for integer_stack_with_average.
// Uses isa_pkg and the RTL; drives push/pop beats, predicts each result beat, compares all fields.
// Random gaps on both sides, one long output hold-off, and a cycle limit on the run.
`default_nettype none
module tb_top;
  import isa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 256;
  localparam int GAP_MAX     = 13;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 60;
  localparam int CYCLE_LIMIT = 800000;

  typedef struct {
    logic                    func;
    logic signed [VAL_W-1:0] value;
  } stack_op_t;

  typedef struct {
    logic signed [VAL_W-1:0]   top_elem;
    logic                      stack_empty;
    logic [CNT_OUT_W-1:0]      element_count;
    logic signed [SUM_W-1:0]   mean_fixed;
    logic                      mean_valid;
    logic [STATUS_W-1:0]       status;
  } stack_view_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_func = FUNC_PUSH;
  logic signed [VAL_W-1:0]       in_push_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [VAL_W-1:0]       out_top_elem;
  logic                          out_stack_empty;
  logic [CNT_OUT_W-1:0]          out_element_count;
  logic signed [SUM_W-1:0]       out_mean_fixed;
  logic                          out_mean_valid;
  logic [STATUS_W-1:0]           out_status;

  stack_op_t   pending_ops[$];
  stack_view_t expected_views[$];

  logic [VAL_W-1:0]        shadow_stack[DEPTH];
  int                      shadow_depth = 0;
  logic signed [SUM_W-1:0] shadow_sum = '0;

  int plan_depth = 0;
  int accepted_count = 0;
  int beat_count = 0;
  int fail_count = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycle_count = 0;

  integer_stack_with_average #(
    .STACK_DEPTH(DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_top_elem     (out_top_elem),
    .out_stack_empty  (out_stack_empty),
    .out_element_count(out_element_count),
    .out_mean_fixed   (out_mean_fixed),
    .out_mean_valid   (out_mean_valid),
    .out_status       (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic stack_view_t apply_stack_op(logic func, logic signed [VAL_W-1:0] value);
    stack_view_t view;
    longint      scaled;
    view.status = STATUS_OK;
    if (func == FUNC_PUSH) begin
      if (shadow_depth >= DEPTH) begin
        view.status = STATUS_PUSH_FULL;
      end else begin
        shadow_stack[shadow_depth] = value;
        shadow_depth++;
        shadow_sum = shadow_sum + {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};
      end
    end else begin
      if (shadow_depth == 0) begin
        view.status = STATUS_POP_EMPTY;
      end else begin
        shadow_depth--;
        shadow_sum = shadow_sum - {{(SUM_W-VAL_W){shadow_stack[shadow_depth][VAL_W-1]}},
                                   shadow_stack[shadow_depth]};
      end
    end
    view.stack_empty   = (shadow_depth == 0);
    view.element_count = shadow_depth[CNT_OUT_W-1:0];
    if (shadow_depth > 0) begin
      scaled = (longint'(shadow_sum) * 256) / longint'(shadow_depth);
      view.top_elem   = shadow_stack[shadow_depth-1];
      view.mean_fixed = scaled[SUM_W-1:0];
      view.mean_valid = 1'b1;
    end else begin
      view.top_elem   = '0;
      view.mean_fixed = '0;
      view.mean_valid = 1'b0;
    end
    return view;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(15, 0))
      0: v = 32'sh7FFF_FFFF;
      1: v = 32'sh8000_0000;
      2: v = '0;
      3: v = -32'sd1;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic add_op(logic func, logic signed [VAL_W-1:0] value);
    stack_op_t op;
    op.func  = func;
    op.value = value;
    pending_ops.insert(pending_ops.size(), op);
    if (func == FUNC_PUSH && plan_depth < DEPTH) plan_depth++;
    if (func == FUNC_POP && plan_depth > 0) plan_depth--;
  endtask

  task automatic check_field(string name, logic [SUM_W-1:0] exp_v, logic [SUM_W-1:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t mismatch %s: expected %h, actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // driver
  always @(posedge clk) begin
    stack_op_t op;
    logic      fire;
    int        gap_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      fire     = in_valid && !in_stall;
      gap_next = tx_gap;
      if (fire) begin
        expected_views.insert(expected_views.size(), apply_stack_op(in_func, in_push_value));
        accepted_count <= accepted_count + 1;
        gap_next = ((accepted_count / 128) % 3 != 0) ? $urandom_range(GAP_MAX, 0) : 0;
      end else if (!in_valid && gap_next != 0) begin
        gap_next--;
      end
      if ((fire || !in_valid) && gap_next == 0 && pending_ops.size() != 0) begin
        op = pending_ops.pop_front();
        in_func       <= op.func;
        in_push_value <= op.value;
        in_valid      <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      tx_gap <= gap_next;
    end
  end

  // receiver stall
  always @(posedge clk) begin
    int gap_next;
    if (!rst_n) begin
      rx_gap    <= 0;
      out_stall <= 1'b0;
    end else begin
      gap_next = rx_gap;
      if (out_valid && !out_stall) begin
        gap_next = ((beat_count / 150) % 2 == 1) ? $urandom_range(GAP_MAX, 0) : 0;
      end else if (gap_next != 0) begin
        gap_next--;
      end
      rx_gap    <= gap_next;
      out_stall <= (gap_next != 0) || (hold_left != 0);
    end
  end

  // long output hold-off while input keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (beat_count == HOLD_AT && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    stack_view_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      beat_count <= beat_count + 1;
      if (expected_views.size() == 0) begin
        fail_count++;
        $display("%0t unexpected beat: expected none, actual top %h count %0d status %0d",
                 $realtime, out_top_elem, out_element_count, out_status);
      end else begin
        exp_v = expected_views.pop_front();
        check_field("top_elem", SUM_W'(unsigned'(exp_v.top_elem)),
                    SUM_W'(unsigned'(out_top_elem)));
        check_field("stack_empty", SUM_W'(exp_v.stack_empty), SUM_W'(out_stack_empty));
        check_field("element_count", SUM_W'(exp_v.element_count), SUM_W'(out_element_count));
        check_field("mean_fixed", exp_v.mean_fixed, out_mean_fixed);
        check_field("mean_valid", SUM_W'(exp_v.mean_valid), SUM_W'(out_mean_valid));
        check_field("status", SUM_W'(exp_v.status), SUM_W'(out_status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int seg_len;
    int push_pct;
    // directed: extremes, empty pops, truncation toward zero
    add_op(FUNC_POP, 32'sh1234_5678);
    add_op(FUNC_PUSH, 32'sh7FFF_FFFF);
    add_op(FUNC_PUSH, 32'sh8000_0000);
    add_op(FUNC_PUSH, -32'sd1);
    add_op(FUNC_PUSH, 32'sd0);
    add_op(FUNC_PUSH, 32'sd1);
    add_op(FUNC_PUSH, 32'sh5555_5555);
    add_op(FUNC_PUSH, 32'shAAAA_AAAA);
    repeat (7) add_op(FUNC_POP, 32'shFFFF_FFFF);
    add_op(FUNC_POP, 32'sh0000_0000);
    add_op(FUNC_PUSH, -32'sd1);
    add_op(FUNC_PUSH, 32'sd0);
    add_op(FUNC_PUSH, 32'sd0);
    repeat (3) add_op(FUNC_POP, $urandom());
    add_op(FUNC_PUSH, 32'sh7FFF_FFFF);
    add_op(FUNC_PUSH, 32'sh7FFF_FFFF);
    repeat (2) add_op(FUNC_POP, $urandom());
    // fill with the largest value, overflow, drain
    while (plan_depth < DEPTH) add_op(FUNC_PUSH, 32'sh7FFF_FFFF);
    repeat (2) add_op(FUNC_PUSH, $urandom());
    while (plan_depth > 0) add_op(FUNC_POP, $urandom());
    add_op(FUNC_POP, $urandom());
    // fill with the smallest value, overflow, then wander from full
    while (plan_depth < DEPTH) add_op(FUNC_PUSH, 32'sh8000_0000);
    repeat (2) add_op(FUNC_PUSH, $urandom());
    // random walk: push-heavy, balanced and pop-heavy stretches
    while (pending_ops.size() < 1450) begin
      seg_len = $urandom_range(96, 16);
      case ($urandom_range(2, 0))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      repeat (seg_len) begin
        if ($urandom_range(99, 0) < push_pct) add_op(FUNC_PUSH, pick_value());
        else add_op(FUNC_POP, $urandom());
      end
    end
    while (plan_depth > 0) add_op(FUNC_POP, $urandom());
    add_op(FUNC_POP, $urandom());

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_ops.size() != 0 || in_valid || expected_views.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
